// ===== hdl/mvcl_pkg.sv =====
package mvcl_pkg;

   // Parameter defaults
   localparam int VEL_WIDTH_DEF   = 32;
   localparam int WHEEL_WIDTH_DEF = 16;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_X   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_Y   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_YAW = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LIN_GAIN  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ROT_GAIN  = 3'd5;

   // Register widths and reset values
   localparam int ACCEL_W   = 24;
   localparam int GAIN_W    = 24;
   localparam int TIMEOUT_W = 16;
   localparam int TIME_W    = 32;
   localparam int CMD_W     = 32;

   localparam logic [ACCEL_W-1:0]   ACCEL_RESET    = 24'd655;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET  = 16'd1000;
   localparam logic [GAIN_W-1:0]    LIN_GAIN_RESET = 24'd655360;
   localparam logic [GAIN_W-1:0]    ROT_GAIN_RESET = 24'd65536;

   // Shared multiplier: unsigned A times signed B
   localparam int MUL_A_W = 24;
   localparam int MUL_B_W = 33;
   localparam int PROD_W  = MUL_A_W + 1 + MUL_B_W;
   localparam int SPLIT_W = 24;

   // Degree scaling: 180/pi in Q16, magnitude clamp at 2^42
   localparam logic [MUL_A_W-1:0] DEG_K = 24'd3754936;
   localparam int MAG_W   = 43;
   localparam logic [MAG_W-1:0] MAG_CLAMP = 43'h400_0000_0000;
   localparam int DEG_LSB = 32;
   localparam int DEG_W   = 33;

   // Fixed point shift of the gain products
   localparam int GAIN_FRAC = 16;

   // Multiplier operations
   typedef enum logic [2:0] {
      OP_NONE,
      OP_LIMIT,
      OP_GAIN_LO,
      OP_GAIN_HI,
      OP_WHEEL_LO,
      OP_WHEEL_HI
   } op_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LIMIT,
      ST_GAIN,
      ST_GDRAIN,
      ST_MAG,
      ST_WHEEL,
      ST_WDRAIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic       load_cmd;
      logic       load_stop;
      op_type     op;
      logic [1:0] lane;
      logic       mag_load;
      logic       rsp_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_tick;
      logic stop_hit;
   } ctrl_status_type;

endpackage

// ===== hdl/mvcl_mul.sv =====
module mvcl_mul (
   input  logic                                clock,
   input  logic [mvcl_pkg::MUL_A_W-1:0]        mul_a,
   input  logic signed [mvcl_pkg::MUL_B_W-1:0] mul_b,
   output logic signed [mvcl_pkg::PROD_W-1:0]  mul_prod
);
   import mvcl_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   // Multiply, register the product
   assign prod_in = $signed({1'b0, mul_a}) * mul_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign mul_prod = prod_ff;

endmodule

// ===== hdl/mvcl_ctrl.sv =====
module mvcl_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  mvcl_pkg::ctrl_status_type status,
   output mvcl_pkg::ctrl_cmd_type    cmd
);
   import mvcl_pkg::*;

   state_type  state_ff, state_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (req_valid) begin
               if (!status.is_tick) begin
                  state_in = ST_LIMIT;
               end else if (status.stop_hit) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_LIMIT: begin
            if (cnt_ff == 3'd2) begin
               state_in = ST_GAIN;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         ST_GAIN: begin
            if (cnt_ff == 3'd5) begin
               state_in = ST_GDRAIN;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         ST_GDRAIN: begin
            state_in = ST_MAG;
         end
         ST_MAG: begin
            state_in = ST_WHEEL;
            cnt_in   = '0;
         end
         ST_WHEEL: begin
            if (cnt_ff == 3'd7) begin
               state_in = ST_WDRAIN;
            end
            cnt_in = cnt_ff + 3'd1;
         end
         ST_WDRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      cmd       = '0;
      cmd.op    = OP_NONE;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_cmd  = req_valid && !status.is_tick;
            cmd.load_stop = req_valid && status.is_tick && status.stop_hit;
         end
         ST_LIMIT: begin
            cmd.op   = OP_LIMIT;
            cmd.lane = cnt_ff[1:0];
         end
         ST_GAIN: begin
            cmd.op   = cnt_ff[0] ? OP_GAIN_HI : OP_GAIN_LO;
            cmd.lane = cnt_ff[2:1];
         end
         ST_MAG: begin
            cmd.mag_load = 1'b1;
         end
         ST_WHEEL: begin
            cmd.op   = cnt_ff[0] ? OP_WHEEL_HI : OP_WHEEL_LO;
            cmd.lane = cnt_ff[2:1];
         end
         ST_DONE: begin
            cmd.rsp_load = out_free;
         end
         default: begin
            cmd.op = OP_NONE;
         end
      endcase
   end

   // Output register valid: set on load, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hdl/mvcl_datapath.sv =====
module mvcl_datapath #(
   parameter int VEL_WIDTH   = mvcl_pkg::VEL_WIDTH_DEF,
   parameter int WHEEL_WIDTH = mvcl_pkg::WHEEL_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_wr_en,
   input  logic [mvcl_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [mvcl_pkg::CSR_DATA_W-1:0]        csr_wr_data,
   input  logic                                   req_type,
   input  logic [mvcl_pkg::TIME_W-1:0]            req_now_ms,
   input  logic signed [mvcl_pkg::CMD_W-1:0]      req_cmd_vx,
   input  logic signed [mvcl_pkg::CMD_W-1:0]      req_cmd_vy,
   input  logic signed [mvcl_pkg::CMD_W-1:0]      req_cmd_wz,
   input  mvcl_pkg::ctrl_cmd_type                 cmd,
   output mvcl_pkg::ctrl_status_type              status,
   output logic signed [WHEEL_WIDTH-1:0]          rsp_wheel_front_left,
   output logic signed [WHEEL_WIDTH-1:0]          rsp_wheel_front_right,
   output logic signed [WHEEL_WIDTH-1:0]          rsp_wheel_rear_left,
   output logic signed [WHEEL_WIDTH-1:0]          rsp_wheel_rear_right,
   output logic                                   rsp_servo_start,
   output logic                                   rsp_servo_stop
);
   import mvcl_pkg::*;

   localparam int TW     = (VEL_WIDTH > CMD_W) ? VEL_WIDTH : CMD_W;
   localparam int LIM_W  = ACCEL_W + TIME_W;
   localparam int CW     = (VEL_WIDTH + 2 > LIM_W + 2) ? VEL_WIDTH + 2 : LIM_W + 2;
   localparam int SW     = VEL_WIDTH + 1;
   localparam int SX_W   = (SW > SPLIT_W + 1) ? SW : SPLIT_W + 1;
   localparam int GP_W   = VEL_WIDTH + GAIN_W - GAIN_FRAC + 1;
   localparam int WS_W   = GP_W + 1;
   localparam int MW     = (WS_W > MAG_W) ? WS_W : MAG_W;
   localparam int FULL_W = PROD_W + SPLIT_W;

   // Configuration registers
   logic [ACCEL_W-1:0]   accel_ff [0:2];
   logic [TIMEOUT_W-1:0] timeout_ff;
   logic [GAIN_W-1:0]    lin_gain_ff;
   logic [GAIN_W-1:0]    rot_gain_ff;

   // Block state
   logic signed [VEL_WIDTH-1:0] vel_ff [0:2];
   logic [TIME_W-1:0]           last_ff;
   logic                        servo_ff;
   op_type                      op_ff;
   logic [1:0]                  lane_ff;

   // Working registers
   logic signed [VEL_WIDTH-1:0]  tgt_ff [0:2];
   logic [TIME_W-1:0]            dt_ff;
   logic                         zero_ff;
   logic                         start_ff;
   logic                         stop_ff;
   logic signed [PROD_W-1:0]     acc_ff;
   logic signed [GP_W-1:0]       gp_ff [0:2];
   logic [MAG_W-1:0]             mag_ff [0:3];
   logic                         neg_ff [0:3];
   logic signed [WHEEL_WIDTH-1:0] wheel_ff [0:3];

   logic [MUL_A_W-1:0]        mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  mul_prod;

   logic [TIME_W-1:0]         dt_now;
   logic signed [SW-1:0]      s_sel;
   logic signed [SX_W-1:0]    sx;
   logic [ACCEL_W-1:0]        accel_sel;
   logic [MAG_W-1:0]          mag_sel;
   logic signed [FULL_W-1:0]  full;
   logic signed [VEL_WIDTH-1:0] cur_sel;
   logic signed [VEL_WIDTH-1:0] tgt_sel;
   logic signed [VEL_WIDTH-1:0] vel_next;
   logic signed [WS_W-1:0]    wsum [0:3];

   function automatic logic signed [VEL_WIDTH-1:0] sat_tgt(input logic signed [CMD_W-1:0] c);
      logic signed [TW-1:0] e;
      logic signed [TW-1:0] hi;
      logic signed [TW-1:0] lo;
      e  = TW'(c);
      hi = TW'($signed({1'b0, {(VEL_WIDTH-1){1'b1}}}));
      lo = ~hi;
      if (e > hi) begin
         e = hi;
      end else if (e < lo) begin
         e = lo;
      end
      return e[VEL_WIDTH-1:0];
   endfunction

   function automatic logic signed [VEL_WIDTH-1:0] approach(
      input logic signed [VEL_WIDTH-1:0] cur,
      input logic signed [VEL_WIDTH-1:0] tgt,
      input logic [LIM_W-1:0]            lim
   );
      logic signed [CW-1:0] cur_e;
      logic signed [CW-1:0] tgt_e;
      logic signed [CW-1:0] lim_e;
      logic signed [CW-1:0] delta;
      logic signed [CW-1:0] res;
      cur_e = CW'(cur);
      tgt_e = CW'(tgt);
      lim_e = $signed(CW'(lim));
      delta = tgt_e - cur_e;
      if (delta > lim_e) begin
         res = cur_e + lim_e;
      end else if (delta < -lim_e) begin
         res = cur_e - lim_e;
      end else begin
         res = tgt_e;
      end
      return res[VEL_WIDTH-1:0];
   endfunction

   function automatic logic signed [WHEEL_WIDTH-1:0] sat_wheel(
      input logic [DEG_W-1:0] deg,
      input logic             neg
   );
      logic [DEG_W-1:0] lim;
      logic [DEG_W-1:0] d;
      logic [DEG_W-1:0] res;
      lim = DEG_W'(1) << (WHEEL_WIDTH - 1);
      if (!neg) begin
         lim = lim - DEG_W'(1);
      end
      d = (deg > lim) ? lim : deg;
      res = neg ? (~d + DEG_W'(1)) : d;
      return $signed(res[WHEEL_WIDTH-1:0]);
   endfunction

   // Safety timeout check against the incoming transaction
   assign dt_now          = req_now_ms - last_ff;
   assign status.is_tick  = req_type;
   assign status.stop_hit = servo_ff && (dt_now >= TIME_W'(timeout_ff));

   // Select gain operand: x+y, x-y or yaw rate
   always_comb begin
      case (cmd.lane)
         2'd0:    s_sel = SW'(vel_ff[0]) + SW'(vel_ff[1]);
         2'd1:    s_sel = SW'(vel_ff[0]) - SW'(vel_ff[1]);
         default: s_sel = SW'(vel_ff[2]);
      endcase
      sx = SX_W'(s_sel);
   end

   always_comb begin
      case (cmd.lane)
         2'd1:    accel_sel = accel_ff[1];
         2'd2:    accel_sel = accel_ff[2];
         default: accel_sel = accel_ff[0];
      endcase
      mag_sel = mag_ff[cmd.lane];
   end

   // Drive the shared multiplier
   always_comb begin
      case (cmd.op)
         OP_LIMIT: begin
            mul_a = accel_sel;
            mul_b = $signed({1'b0, dt_ff});
         end
         OP_GAIN_LO: begin
            mul_a = (cmd.lane == 2'd2) ? rot_gain_ff : lin_gain_ff;
            mul_b = $signed({{(MUL_B_W-SPLIT_W){1'b0}}, sx[SPLIT_W-1:0]});
         end
         OP_GAIN_HI: begin
            mul_a = (cmd.lane == 2'd2) ? rot_gain_ff : lin_gain_ff;
            mul_b = MUL_B_W'($signed(sx[SX_W-1:SPLIT_W]));
         end
         OP_WHEEL_LO: begin
            mul_a = DEG_K;
            mul_b = $signed({{(MUL_B_W-SPLIT_W){1'b0}}, mag_sel[SPLIT_W-1:0]});
         end
         OP_WHEEL_HI: begin
            mul_a = DEG_K;
            mul_b = $signed({{(MUL_B_W-MAG_W+SPLIT_W){1'b0}}, mag_sel[MAG_W-1:SPLIT_W]});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   mvcl_mul u_mul (
      .clock    (clock),
      .mul_a    (mul_a),
      .mul_b    (mul_b),
      .mul_prod (mul_prod)
   );

   // Join high and low partial products
   assign full = (FULL_W'(mul_prod) <<< SPLIT_W) + FULL_W'(acc_ff);

   // Acceleration step for the lane whose limit just came out
   always_comb begin
      case (lane_ff)
         2'd1: begin
            cur_sel = vel_ff[1];
            tgt_sel = tgt_ff[1];
         end
         2'd2: begin
            cur_sel = vel_ff[2];
            tgt_sel = tgt_ff[2];
         end
         default: begin
            cur_sel = vel_ff[0];
            tgt_sel = tgt_ff[0];
         end
      endcase
      vel_next = zero_ff ? '0 : approach(cur_sel, tgt_sel, mul_prod[LIM_W-1:0]);
   end

   // Mecanum mixing: FL, FR, RL, RR
   assign wsum[0] = WS_W'(gp_ff[2]) + WS_W'(gp_ff[1]);
   assign wsum[1] = WS_W'(gp_ff[2]) - WS_W'(gp_ff[0]);
   assign wsum[2] = WS_W'(gp_ff[2]) + WS_W'(gp_ff[0]);
   assign wsum[3] = WS_W'(gp_ff[2]) - WS_W'(gp_ff[1]);

   // Configuration and block state
   always_ff @(posedge clock) begin
      if (reset) begin
         accel_ff[0] <= ACCEL_RESET;
         accel_ff[1] <= ACCEL_RESET;
         accel_ff[2] <= ACCEL_RESET;
         timeout_ff  <= TIMEOUT_RESET;
         lin_gain_ff <= LIN_GAIN_RESET;
         rot_gain_ff <= ROT_GAIN_RESET;
         vel_ff[0]   <= '0;
         vel_ff[1]   <= '0;
         vel_ff[2]   <= '0;
         last_ff     <= '0;
         servo_ff    <= 1'b0;
         op_ff       <= OP_NONE;
         lane_ff     <= '0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_ACCEL_X:   accel_ff[0] <= csr_wr_data;
               CSR_ACCEL_Y:   accel_ff[1] <= csr_wr_data;
               CSR_ACCEL_YAW: accel_ff[2] <= csr_wr_data;
               CSR_TIMEOUT:   timeout_ff  <= csr_wr_data[TIMEOUT_W-1:0];
               CSR_LIN_GAIN:  lin_gain_ff <= csr_wr_data;
               CSR_ROT_GAIN:  rot_gain_ff <= csr_wr_data;
               default: ;
            endcase
         end
         op_ff   <= cmd.op;
         lane_ff <= cmd.lane;
         if (cmd.load_cmd) begin
            last_ff  <= req_now_ms;
            servo_ff <= 1'b1;
         end
         if (cmd.load_stop) begin
            vel_ff[0] <= '0;
            vel_ff[1] <= '0;
            vel_ff[2] <= '0;
            servo_ff  <= 1'b0;
         end
         if (op_ff == OP_LIMIT) begin
            vel_ff[lane_ff] <= vel_next;
         end
      end
   end

   // Working registers and output register
   always_ff @(posedge clock) begin
      if (cmd.load_cmd) begin
         tgt_ff[0] <= sat_tgt(req_cmd_vx);
         tgt_ff[1] <= sat_tgt(req_cmd_vy);
         tgt_ff[2] <= sat_tgt(req_cmd_wz);
         dt_ff     <= dt_now;
         zero_ff   <= (req_cmd_vx == '0) && (req_cmd_vy == '0) && (req_cmd_wz == '0);
         start_ff  <= !servo_ff;
         stop_ff   <= 1'b0;
      end
      if (cmd.load_stop) begin
         for (int k = 0; k < 4; k++) begin
            wheel_ff[k] <= '0;
         end
         start_ff <= 1'b0;
         stop_ff  <= 1'b1;
      end
      case (op_ff)
         OP_GAIN_LO, OP_WHEEL_LO: begin
            acc_ff <= mul_prod;
         end
         OP_GAIN_HI: begin
            gp_ff[lane_ff] <= full[GP_W+GAIN_FRAC-1:GAIN_FRAC];
         end
         OP_WHEEL_HI: begin
            wheel_ff[lane_ff] <= sat_wheel(full[DEG_LSB+DEG_W-1:DEG_LSB], neg_ff[lane_ff]);
         end
         default: ;
      endcase
      // Take magnitudes and clamp for degree scaling
      if (cmd.mag_load) begin
         for (int k = 0; k < 4; k++) begin
            logic [MW-1:0] m;
            m = wsum[k][WS_W-1] ? MW'(-wsum[k]) : MW'(wsum[k]);
            if (m > MW'(MAG_CLAMP)) begin
               m = MW'(MAG_CLAMP);
            end
            mag_ff[k] <= m[MAG_W-1:0];
            neg_ff[k] <= wsum[k][WS_W-1];
         end
      end
      if (cmd.rsp_load) begin
         rsp_wheel_front_left  <= wheel_ff[0];
         rsp_wheel_front_right <= wheel_ff[1];
         rsp_wheel_rear_left   <= wheel_ff[2];
         rsp_wheel_rear_right  <= wheel_ff[3];
         rsp_servo_start       <= start_ff;
         rsp_servo_stop        <= stop_ff;
      end
   end

endmodule

// ===== hdl/mecanum_velocity_command_limiter_unit.sv =====
// Velocity command: LIMIT, GAIN, GDRAIN, MAG, WHEEL, WDRAIN and DONE, then rsp_valid;
// a new request is taken only in idle. Safety tick: taken while idle; a stopping tick
// goes to DONE, which waits for a free output register. Command time is set by one
// shared 24x33 multiplier: 3 limit products, 6 gain partial products and 8
// degree-scaling partial products, one per cycle. Synchronous reset clears velocities,
// time stamp and servo flag and loads the register defaults; no clearing pass is needed.
module mecanum_velocity_command_limiter_unit #(
   parameter int VEL_WIDTH   = mvcl_pkg::VEL_WIDTH_DEF,
   parameter int WHEEL_WIDTH = mvcl_pkg::WHEEL_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [mvcl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mvcl_pkg::CSR_DATA_W-1:0]   csr_wr_data,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_type,
   input  logic [mvcl_pkg::TIME_W-1:0]       req_now_ms,
   input  logic signed [mvcl_pkg::CMD_W-1:0] req_cmd_vx,
   input  logic signed [mvcl_pkg::CMD_W-1:0] req_cmd_vy,
   input  logic signed [mvcl_pkg::CMD_W-1:0] req_cmd_wz,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [WHEEL_WIDTH-1:0]     rsp_wheel_front_left,
   output logic signed [WHEEL_WIDTH-1:0]     rsp_wheel_front_right,
   output logic signed [WHEEL_WIDTH-1:0]     rsp_wheel_rear_left,
   output logic signed [WHEEL_WIDTH-1:0]     rsp_wheel_rear_right,
   output logic                              rsp_servo_start,
   output logic                              rsp_servo_stop
);
   import mvcl_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   // Sequence the transaction
   mvcl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Limit, mix and scale
   mvcl_datapath #(
      .VEL_WIDTH   (VEL_WIDTH),
      .WHEEL_WIDTH (WHEEL_WIDTH)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .csr_wr_en             (csr_wr_en),
      .csr_index             (csr_index),
      .csr_wr_data           (csr_wr_data),
      .req_type              (req_type),
      .req_now_ms            (req_now_ms),
      .req_cmd_vx            (req_cmd_vx),
      .req_cmd_vy            (req_cmd_vy),
      .req_cmd_wz            (req_cmd_wz),
      .cmd                   (cmd),
      .status                (status),
      .rsp_wheel_front_left  (rsp_wheel_front_left),
      .rsp_wheel_front_right (rsp_wheel_front_right),
      .rsp_wheel_rear_left   (rsp_wheel_rear_left),
      .rsp_wheel_rear_right  (rsp_wheel_rear_right),
      .rsp_servo_start       (rsp_servo_start),
      .rsp_servo_stop        (rsp_servo_stop)
   );

endmodule

// ===== tb/sv/tb_mecanum_velocity_command_limiter_unit.sv =====
`timescale 1ns / 100ps

module tb_mecanum_velocity_command_limiter_unit;
   import mvcl_pkg::*;

   localparam logic REQ_COMMAND = 1'b0;
   localparam logic REQ_TICK    = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_6 = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_7 = 3'd7;

   localparam int SETTLE_CYCLES    = 32;
   localparam int CYCLE_LIMIT      = 600000;
   localparam int PHASE_COUNT      = 6;
   localparam int RANDOM_PER_PHASE = 250;
   localparam int CALM_TAIL_ITEMS  = 80;
   localparam int REPORT_LIMIT     = 10;

   localparam logic [63:0] DEG_PER_RAD_Q16 = 64'd3754936;
   localparam logic [63:0] MAG_LIMIT       = 64'd1 << 42;

   typedef struct packed {
      logic signed [15:0] front_left;
      logic signed [15:0] front_right;
      logic signed [15:0] rear_left;
      logic signed [15:0] rear_right;
      logic               servo_start;
      logic               servo_stop;
   } wheel_cmd_type;

   typedef struct packed {
      logic        kind;
      logic [31:0] now_ms;
      logic [31:0] vx;
      logic [31:0] vy;
      logic [31:0] wz;
   } velocity_req_type;

   typedef struct packed {
      velocity_req_type req;
      logic             pinned;
      logic             pinned_hit;
      wheel_cmd_type    pinned_res;
   } directed_row_type;

   localparam wheel_cmd_type W_NONE = '0;
   localparam wheel_cmd_type W_START = '{front_left: 16'sd0, front_right: 16'sd0,
      rear_left: 16'sd0, rear_right: 16'sd0, servo_start: 1'b1, servo_stop: 1'b0};
   localparam wheel_cmd_type W_STOP = '{front_left: 16'sd0, front_right: 16'sd0,
      rear_left: 16'sd0, rear_right: 16'sd0, servo_start: 1'b0, servo_stop: 1'b1};
   localparam wheel_cmd_type W_SAT_START = '{front_left: 16'sh7FFF, front_right: 16'sh8000,
      rear_left: 16'sh7FFF, rear_right: 16'sh8000, servo_start: 1'b1, servo_stop: 1'b0};

   // Directed rows at reset register values; pinned rows carry a hand-read result
   localparam int DIRECTED_COUNT = 19;
   localparam directed_row_type DIRECTED [0:DIRECTED_COUNT-1] = '{
      '{'{REQ_TICK,    32'd0,        32'h0,        32'h0,        32'h0},        1'b1, 1'b0, W_NONE},
      '{'{REQ_COMMAND, 32'd0,        32'h0,        32'h0,        32'h0},        1'b1, 1'b1, W_START},
      '{'{REQ_COMMAND, 32'd0,        32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF}, 1'b1, 1'b1, W_NONE},
      '{'{REQ_TICK,    32'd999,      32'h0,        32'h0,        32'h0},        1'b1, 1'b0, W_NONE},
      '{'{REQ_TICK,    32'd1000,     32'h0,        32'h0,        32'h0},        1'b1, 1'b1, W_STOP},
      '{'{REQ_TICK,    32'd5000,     32'h0,        32'h0,        32'h0},        1'b1, 1'b0, W_NONE},
      '{'{REQ_COMMAND, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h0,        32'h0},        1'b1, 1'b1,
        W_SAT_START},
      '{'{REQ_COMMAND, 32'd5,        32'h80000000, 32'h7FFFFFFF, 32'h80000000}, 1'b0, 1'b0, W_NONE},
      '{'{REQ_COMMAND, 32'd6,        32'h00010000, 32'hFFFF0000, 32'h00008000}, 1'b0, 1'b0, W_NONE},
      '{'{REQ_COMMAND, 32'd6,        32'h00010000, 32'hFFFF0000, 32'h00008000}, 1'b0, 1'b0, W_NONE},
      '{'{REQ_COMMAND, 32'd106,      32'h00010000, 32'hFFFF0000, 32'h00008000}, 1'b0, 1'b0, W_NONE},
      '{'{REQ_TICK,    32'd1105,     32'h0,        32'h0,        32'h0},        1'b1, 1'b0, W_NONE},
      '{'{REQ_TICK,    32'd1106,     32'h0,        32'h0,        32'h0},        1'b1, 1'b1, W_STOP},
      '{'{REQ_COMMAND, 32'd1106,     32'h0,        32'h0,        32'h0},        1'b1, 1'b1, W_START},
      '{'{REQ_COMMAND, 32'd1110,     32'hFFFFFFFF, 32'h00000001, 32'hFFFFFFFF}, 1'b0, 1'b0, W_NONE},
      '{'{REQ_COMMAND, 32'd2000,     32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF}, 1'b0, 1'b0, W_NONE},
      '{'{REQ_COMMAND, 32'd2000,     32'h0,        32'h0,        32'h0},        1'b1, 1'b1, W_NONE},
      '{'{REQ_TICK,    32'hFFFFFFFF, 32'h0,        32'h0,        32'h0},        1'b1, 1'b1, W_STOP},
      '{'{REQ_TICK,    32'd0,        32'h0,        32'h0,        32'h0},        1'b1, 1'b0, W_NONE}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  csr_wr_en   = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index   = '0;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;

   logic                     req_valid  = 1'b0;
   logic                     req_ready;
   logic                     req_type   = REQ_COMMAND;
   logic [TIME_W-1:0]        req_now_ms = '0;
   logic signed [CMD_W-1:0]  req_cmd_vx = '0;
   logic signed [CMD_W-1:0]  req_cmd_vy = '0;
   logic signed [CMD_W-1:0]  req_cmd_wz = '0;

   // Hand-read expectation travels with the request payload
   logic          req_pinned     = 1'b0;
   logic          req_pinned_hit = 1'b0;
   wheel_cmd_type req_pinned_res = '0;

   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [15:0] rsp_wheel_front_left;
   logic signed [15:0] rsp_wheel_front_right;
   logic signed [15:0] rsp_wheel_rear_left;
   logic signed [15:0] rsp_wheel_rear_right;
   logic               rsp_servo_start;
   logic               rsp_servo_stop;

   // Limiter state and register copies, starting at reset values
   logic [23:0]        accel_x_q   = ACCEL_RESET;
   logic [23:0]        accel_y_q   = ACCEL_RESET;
   logic [23:0]        accel_yaw_q = ACCEL_RESET;
   logic [15:0]        timeout_q   = TIMEOUT_RESET;
   logic [23:0]        lin_gain_q  = LIN_GAIN_RESET;
   logic [23:0]        rot_gain_q  = ROT_GAIN_RESET;
   logic signed [63:0] vel_x       = '0;
   logic signed [63:0] vel_y       = '0;
   logic signed [63:0] vel_yaw     = '0;
   logic [31:0]        last_cmd_ms = '0;
   logic               servo_is_on = 1'b0;

   wheel_cmd_type wheel_cmd_q [$];

   int  error_count    = 0;
   int  checked_count  = 0;
   int  command_count  = 0;
   int  tick_count     = 0;
   int  stop_count     = 0;
   int  setting_count  = 1;
   int  cycle_count;
   bit  idle_on        = 1'b1;
   bit  calm_tail      = 1'b0;
   int  stall_left     = 0;
   logic [31:0] gen_now      = '0;
   logic [31:0] gen_last_cmd = '0;

   mecanum_velocity_command_limiter_unit dut (
      .clock                 (clock),
      .reset                 (reset),
      .csr_wr_en             (csr_wr_en),
      .csr_index             (csr_index),
      .csr_wr_data           (csr_wr_data),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_type              (req_type),
      .req_now_ms            (req_now_ms),
      .req_cmd_vx            (req_cmd_vx),
      .req_cmd_vy            (req_cmd_vy),
      .req_cmd_wz            (req_cmd_wz),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_wheel_front_left  (rsp_wheel_front_left),
      .rsp_wheel_front_right (rsp_wheel_front_right),
      .rsp_wheel_rear_left   (rsp_wheel_rear_left),
      .rsp_wheel_rear_right  (rsp_wheel_rear_right),
      .rsp_servo_start       (rsp_servo_start),
      .rsp_servo_stop        (rsp_servo_stop)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Move one velocity toward its target by at most accel * dt
   function automatic logic signed [63:0] step_toward(input logic signed [63:0] cur,
                                                      input logic signed [63:0] tgt,
                                                      input logic [23:0] accel,
                                                      input logic [31:0] dt);
      logic [63:0]        span;
      logic signed [63:0] limit;
      logic signed [63:0] delta;
      span  = 64'(accel) * 64'(dt);
      limit = $signed(span);
      delta = tgt - cur;
      if (delta > limit) return cur + limit;
      if (delta < -limit) return cur - limit;
      return tgt;
   endfunction

   // Q8.16 gain times Q16.16 value, floored
   function automatic logic signed [63:0] gain_product(input logic [23:0] gain,
                                                       input logic signed [63:0] s);
      logic signed [63:0] whole;
      logic [63:0]        frac;
      whole = s >>> 16;
      frac  = (64'(gain) * 64'(s[15:0])) >> 16;
      return $signed({40'd0, gain}) * whole + $signed(frac);
   endfunction

   // Convert rad/s in Q16.16 to saturated deg/s
   function automatic logic signed [15:0] wheel_deg(input logic signed [63:0] v);
      logic        neg;
      logic [63:0] mag;
      logic [63:0] deg;
      logic [63:0] cap;
      neg = (v < 0);
      mag = neg ? $unsigned(-v) : $unsigned(v);
      if (mag > MAG_LIMIT) mag = MAG_LIMIT;
      deg = (mag * DEG_PER_RAD_Q16) >> 32;
      cap = neg ? 64'd32768 : 64'd32767;
      if (deg > cap) deg = cap;
      if (neg) deg = -deg;
      return deg[15:0];
   endfunction

   // Apply one accepted request to the limiter state and form its wheel command
   task automatic advance_limiter(input velocity_req_type it, output logic hit,
                                  output wheel_cmd_type res);
      logic [31:0]        dt;
      logic signed [63:0] rot;
      logic signed [63:0] sum_term;
      logic signed [63:0] diff_term;
      dt  = it.now_ms - last_cmd_ms;
      res = '0;
      hit = 1'b0;
      if (it.kind == REQ_TICK) begin
         if (dt >= 32'(timeout_q) && servo_is_on) begin
            vel_x          = '0;
            vel_y          = '0;
            vel_yaw        = '0;
            servo_is_on    = 1'b0;
            res.servo_stop = 1'b1;
            hit            = 1'b1;
         end
      end else begin
         if (it.vx == 32'h0 && it.vy == 32'h0 && it.wz == 32'h0) begin
            vel_x   = '0;
            vel_y   = '0;
            vel_yaw = '0;
         end else begin
            vel_x   = step_toward(vel_x, $signed({{32{it.vx[31]}}, it.vx}), accel_x_q, dt);
            vel_y   = step_toward(vel_y, $signed({{32{it.vy[31]}}, it.vy}), accel_y_q, dt);
            vel_yaw = step_toward(vel_yaw, $signed({{32{it.wz[31]}}, it.wz}), accel_yaw_q, dt);
         end
         res.servo_start = !servo_is_on;
         servo_is_on     = 1'b1;
         hit             = 1'b1;
         rot       = gain_product(rot_gain_q, vel_yaw);
         sum_term  = gain_product(lin_gain_q, vel_x + vel_y);
         diff_term = gain_product(lin_gain_q, vel_x - vel_y);
         res.front_left  = wheel_deg(rot + diff_term);
         res.front_right = wheel_deg(rot - sum_term);
         res.rear_left   = wheel_deg(rot + sum_term);
         res.rear_right  = wheel_deg(rot - diff_term);
         last_cmd_ms     = it.now_ms;
      end
   endtask

   task automatic flag_error(input string what, input wheel_cmd_type want,
                             input wheel_cmd_type got);
      error_count++;
      if (error_count <= REPORT_LIMIT) begin
         $write("%s: expected fl=%0d fr=%0d rl=%0d rr=%0d start=%0b stop=%0b, ",
                what, want.front_left, want.front_right, want.rear_left, want.rear_right,
                want.servo_start, want.servo_stop);
         $display("got fl=%0d fr=%0d rl=%0d rr=%0d start=%0b stop=%0b",
                  got.front_left, got.front_right, got.rear_left, got.rear_right,
                  got.servo_start, got.servo_stop);
      end
   endtask

   // Predict on each request transaction, check each result transaction
   always @(posedge clock) begin : txn_monitor
      velocity_req_type it;
      wheel_cmd_type    res;
      wheel_cmd_type    want;
      wheel_cmd_type    got;
      logic             hit;
      if (!reset && req_valid && req_ready) begin
         it = '{req_type, req_now_ms, req_cmd_vx, req_cmd_vy, req_cmd_wz};
         advance_limiter(it, hit, res);
         if (req_pinned) begin
            hit = req_pinned_hit;
            res = req_pinned_res;
         end
         if (it.kind == REQ_TICK) tick_count++;
         else command_count++;
         if (hit) wheel_cmd_q.push_back(res);
      end
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_wheel_front_left, rsp_wheel_front_right, rsp_wheel_rear_left,
                 rsp_wheel_rear_right, rsp_servo_start, rsp_servo_stop};
         checked_count++;
         if (wheel_cmd_q.size() == 0) begin
            flag_error("unexpected result transaction", W_NONE, got);
         end else begin
            want = wheel_cmd_q.pop_front();
            if (want.servo_stop) stop_count++;
            if (got.front_left !== want.front_left || got.front_right !== want.front_right ||
                got.rear_left !== want.rear_left || got.rear_right !== want.rear_right ||
                got.servo_start !== want.servo_start || got.servo_stop !== want.servo_stop)
               flag_error("wheel command mismatch", want, got);
         end
      end
   end

   // Stall the result side in short random bursts
   always @(posedge clock) begin : ready_driver
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(0, 3);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   function automatic int pick_gap();
      if (idle_on && $urandom_range(0, 2) == 0) return $urandom_range(1, 4);
      return 0;
   endfunction

   // Present one request transaction and hold it until accepted
   task automatic send_request(input velocity_req_type it, input logic pinned,
                               input logic pinned_hit, input wheel_cmd_type pinned_res,
                               input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= it.kind;
      req_now_ms     <= it.now_ms;
      req_cmd_vx     <= it.vx;
      req_cmd_vy     <= it.vy;
      req_cmd_wz     <= it.wz;
      req_pinned     <= pinned;
      req_pinned_hit <= pinned_hit;
      req_pinned_res <= pinned_res;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Hold off the sender until every wheel command is back, then let the block settle
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (wheel_cmd_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      case (idx)
         CSR_ACCEL_X:   accel_x_q   = data;
         CSR_ACCEL_Y:   accel_y_q   = data;
         CSR_ACCEL_YAW: accel_yaw_q = data;
         CSR_TIMEOUT:   timeout_q   = data[TIMEOUT_W-1:0];
         CSR_LIN_GAIN:  lin_gain_q  = data;
         CSR_ROT_GAIN:  rot_gain_q  = data;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Program one register setting per phase, extremes included
   task automatic load_phase_registers(input int phase);
      logic [23:0] ax, ay, aw, tmo, lg, rg;
      case (phase)
         1: begin
            ax = 24'hFFFFFF; ay = 24'hFFFFFF; aw = 24'hFFFFFF;
            tmo = 24'h0; lg = 24'hFFFFFF; rg = 24'hFFFFFF;
         end
         2: begin
            ax = 24'h0; ay = 24'h0; aw = 24'h0;
            tmo = 24'h00FFFF; lg = 24'h0; rg = 24'hFFFFFF;
         end
         3: begin
            ax = 24'($urandom_range(0, 24'hFFFFFF));
            ay = 24'($urandom_range(0, 24'hFFFFFF));
            aw = 24'($urandom_range(0, 24'hFFFFFF));
            // upper bits beyond the timeout width must be dropped
            tmo = {8'hA5, 16'($urandom_range(1, 200))};
            lg = 24'($urandom_range(0, 24'hFFFFFF));
            rg = 24'($urandom_range(0, 24'hFFFFFF));
         end
         4: begin
            ax = 24'($urandom_range(1, 5000)); ay = 24'($urandom_range(1, 5000));
            aw = 24'($urandom_range(1, 5000));
            tmo = 24'($urandom_range(50, 500)); lg = LIN_GAIN_RESET; rg = ROT_GAIN_RESET;
         end
         default: begin
            ax = 24'hFFFFFF; ay = 24'h0; aw = 24'h1;
            tmo = 24'h1; lg = 24'h1; rg = 24'h0;
         end
      endcase
      write_register(CSR_ACCEL_X, ax);
      write_register(CSR_ACCEL_Y, ay);
      write_register(CSR_ACCEL_YAW, aw);
      write_register(CSR_TIMEOUT, tmo);
      write_register(CSR_LIN_GAIN, lg);
      write_register(CSR_ROT_GAIN, rg);
      write_register(CSR_SPARE_6, CSR_DATA_W'($urandom));
      write_register(CSR_SPARE_7, CSR_DATA_W'($urandom));
      csr_wr_en <= 1'b0;
      setting_count++;
   endtask

   function automatic logic [31:0] pick_velocity();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 60) return $urandom_range(0, 32'h7FFFF) - 32'h40000;
      if (sel < 75) return $urandom_range(0, 32'h1FFFFFF) - 32'h1000000;
      if (sel < 85) return $urandom;
      if (sel < 90) return 32'h0;
      if (sel < 95) return 32'h7FFFFFFF;
      return 32'h80000000;
   endfunction

   // Mostly steady command streams with ticks around the timeout, plus raw noise
   task automatic make_request(output velocity_req_type it);
      int pick;
      pick = $urandom_range(0, 99);
      it   = '0;
      if (pick < 10) begin
         it.kind   = 1'($urandom_range(0, 1));
         it.now_ms = $urandom;
         it.vx     = $urandom;
         it.vy     = $urandom;
         it.wz     = $urandom;
         if (it.kind == REQ_COMMAND) gen_last_cmd = it.now_ms;
      end else if (pick < 28) begin
         it.kind = REQ_TICK;
         if ($urandom_range(0, 1) == 0)
            it.now_ms = gen_last_cmd + 32'(timeout_q) + 32'($urandom_range(0, 4)) - 32'd2;
         else
            it.now_ms = gen_last_cmd + $urandom_range(0, 2 * int'(timeout_q) + 2);
      end else begin
         it.kind = REQ_COMMAND;
         gen_now = gen_now + (($urandom_range(0, 9) == 0) ? 32'd0 : $urandom_range(1, 40));
         it.now_ms = gen_now;
         if (pick < 94) begin
            it.vx = pick_velocity();
            it.vy = pick_velocity();
            it.wz = pick_velocity();
         end
         gen_last_cmd = gen_now;
      end
   endtask

   initial begin : stimulus
      velocity_req_type it;
      int               p;
      int               n;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed rows
      for (n = 0; n < DIRECTED_COUNT; n++)
         send_request(DIRECTED[n].req, DIRECTED[n].pinned, DIRECTED[n].pinned_hit,
                      DIRECTED[n].pinned_res, pick_gap());

      // Random phases, one register setting each
      for (p = 0; p < PHASE_COUNT; p++) begin
         drain_results();
         if (p > 0) load_phase_registers(p);
         gen_last_cmd = last_cmd_ms;
         gen_now      = ($urandom_range(0, 3) == 0) ? 32'hFFFFFF00 : last_cmd_ms;
         for (n = 0; n < RANDOM_PER_PHASE; n++) begin
            if (p == PHASE_COUNT - 1 && n == RANDOM_PER_PHASE - CALM_TAIL_ITEMS) begin
               calm_tail = 1'b1;
               idle_on   = 1'b0;
            end
            if (n % 60 == 0 && !calm_tail) idle_on = ($urandom_range(0, 3) != 0);
            if (n == RANDOM_PER_PHASE / 2 && p % 2 == 1) drain_results();
            make_request(it);
            send_request(it, 1'b0, 1'b0, W_NONE, pick_gap());
         end
      end

      drain_results();
      $display("Covered %0d velocity commands and %0d safety ticks over %0d register settings",
               command_count, tick_count, setting_count);
      $display("Checked %0d wheel command transactions, %0d safety stops, %0d errors",
               checked_count, stop_count, error_count);
      if (error_count == 0 && wheel_cmd_q.size() == 0)
         $display("[mecanum_velocity_command_limiter_unit] OK");
      else
         $display("[mecanum_velocity_command_limiter_unit] ERROR");
      $finish;
   end

   // End a hung run
   initial begin : watchdog
      for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clock);
      $display("[mecanum_velocity_command_limiter_unit] ERROR");
      $finish;
   end

endmodule

// ===== mecanum_velocity_command_limiter_unit.f =====
hdl/mvcl_pkg.sv
hdl/mvcl_mul.sv
hdl/mvcl_ctrl.sv
hdl/mvcl_datapath.sv
hdl/mecanum_velocity_command_limiter_unit.sv
tb/sv/tb_mecanum_velocity_command_limiter_unit.sv
